[sv/qtl_pkg.sv]
`default_nettype none
package qtl_pkg;

	localparam int MAX_SIDE   = 16;
	localparam int MAX_TASKS  = 8;
	localparam int MAX_LEVELS = 5;
	localparam int RING_SIZE  = 8;
	localparam int NODE_COUNT = 341;
	localparam int RING_DEPTH = NODE_COUNT * RING_SIZE;

	localparam logic REQ_ACQUIRE = 1'b0;
	localparam logic REQ_RELEASE = 1'b1;
	localparam logic EV_GRANT    = 1'b0;
	localparam logic EV_REJECT   = 1'b1;

	localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
	localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;
	localparam logic [1:0] REG_TASKS       = 2'd2;

	typedef struct packed {
		logic       req_type;
		logic [3:0] cluster_x;
		logic [3:0] cluster_y;
		logic [2:0] task_number;
	} req_t;

	typedef struct packed {
		logic       event_kind;
		logic [3:0] owner_x;
		logic [3:0] owner_y;
		logic [2:0] owner_task;
	} evt_t;

	typedef struct packed {
		logic [4:0] grid_width;
		logic [4:0] grid_height;
		logic [3:0] tasks_per_cluster;
	} cfg_t;

	typedef struct packed {
		logic clr_restart;
		logic clr_step;
		logic load;
		logic holder_drop;
		logic rd_node;
		logic acq_upd;
		logic rel_upd;
		logic gn_init;
		logic gn_ring_rd;
		logic gn_descend;
		logic set_reject;
		logic set_grant_req;
		logic set_grant_root;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic cfg_wr;
		logic clr_last;
		logic bad;
		logic is_holder;
		logic rtype;
		logic full;
		logic held;
		logic rel_pending;
		logic last_lv;
		logic lv_zero;
		logic out_free;
	} sts_t;

	// Node numbering: leaves first, then each coarser level after it.
	function automatic logic [8:0] node_idx(input logic [3:0] x, input logic [3:0] y,
			input logic [2:0] lv);
		logic [8:0] r;
		unique case (lv)
			3'd0: r = {1'b0, y, x};
			3'd1: r = 9'd256 + {3'b0, y[3:1], x[3:1]};
			3'd2: r = 9'd320 + {5'b0, y[3:2], x[3:2]};
			3'd3: r = 9'd336 + {7'b0, y[3], x[3]};
			default: r = 9'd340;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

[sv/qtl_if.sv]
`default_nettype none
interface qtl_req_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [3:0] cluster_x;
	logic [3:0] cluster_y;
	logic [2:0] task_number;

	modport source (output valid, req_type, cluster_x, cluster_y, task_number, input ready);
	modport sink (input valid, req_type, cluster_x, cluster_y, task_number, output ready);
endinterface

interface qtl_evt_if;
	logic       valid;
	logic       ready;
	logic       event_kind;
	logic [3:0] owner_x;
	logic [3:0] owner_y;
	logic [2:0] owner_task;

	modport source (output valid, event_kind, owner_x, owner_y, owner_task, input ready);
	modport sink (input valid, event_kind, owner_x, owner_y, owner_task, output ready);
endinterface
`default_nettype wire

[sv/qtl_ctrl.sv]
`default_nettype none
module qtl_ctrl
	import qtl_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	localparam logic [3:0] S_CLEAR  = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_CHECK  = 4'd2;
	localparam logic [3:0] S_AQ_RD  = 4'd3;
	localparam logic [3:0] S_AQ_UPD = 4'd4;
	localparam logic [3:0] S_RL_RD  = 4'd5;
	localparam logic [3:0] S_RL_UPD = 4'd6;
	localparam logic [3:0] S_GN_RD  = 4'd7;
	localparam logic [3:0] S_GN_RRD = 4'd8;
	localparam logic [3:0] S_GN_USE = 4'd9;
	localparam logic [3:0] S_EMIT   = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_ready = (state_q == S_IDLE) && !sts.cfg_wr;
		if (sts.cfg_wr) begin
			cmd.clr_restart = 1'b1;
			state_d         = S_CLEAR;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					cmd.clr_step = 1'b1;
					if (sts.clr_last) state_d = S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) begin
						cmd.load = 1'b1;
						state_d  = S_CHECK;
					end
				end
				S_CHECK: begin
					if (sts.bad || (sts.rtype == REQ_ACQUIRE && sts.is_holder) ||
							(sts.rtype == REQ_RELEASE && !sts.is_holder)) begin
						cmd.set_reject = 1'b1;
						state_d        = S_EMIT;
					end else if (sts.rtype == REQ_ACQUIRE) begin
						state_d = S_AQ_RD;
					end else begin
						cmd.holder_drop = 1'b1;
						state_d         = S_RL_RD;
					end
				end
				S_AQ_RD: begin
					cmd.rd_node = 1'b1;
					state_d     = S_AQ_UPD;
				end
				S_AQ_UPD: begin
					if (sts.full) begin
						cmd.set_reject = 1'b1;
						state_d        = S_EMIT;
					end else begin
						cmd.acq_upd = 1'b1;
						if (!sts.held) begin
							state_d = S_IDLE;
						end else if (sts.last_lv) begin
							cmd.set_grant_req = 1'b1;
							state_d           = S_EMIT;
						end else begin
							state_d = S_AQ_RD;
						end
					end
				end
				S_RL_RD: begin
					cmd.rd_node = 1'b1;
					state_d     = S_RL_UPD;
				end
				S_RL_UPD: begin
					cmd.rel_upd = 1'b1;
					if (sts.rel_pending && sts.last_lv) begin
						cmd.gn_init = 1'b1;
						state_d     = S_GN_RD;
					end else if (sts.last_lv) begin
						state_d = S_IDLE;
					end else begin
						state_d = S_RL_RD;
					end
				end
				S_GN_RD: begin
					cmd.rd_node = 1'b1;
					state_d     = S_GN_RRD;
				end
				S_GN_RRD: begin
					cmd.gn_ring_rd = 1'b1;
					state_d        = S_GN_USE;
				end
				S_GN_USE: begin
					if (sts.lv_zero) begin
						cmd.set_grant_root = 1'b1;
						state_d            = S_EMIT;
					end else begin
						cmd.gn_descend = 1'b1;
						state_d        = S_GN_RD;
					end
				end
				S_EMIT: begin
					if (sts.out_free) begin
						cmd.out_load = 1'b1;
						state_d      = S_IDLE;
					end
				end
				default: state_d = S_IDLE;
			endcase
		end
	end

	a_ready_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (state_q == S_IDLE) && !cmd.out_load && !cmd.clr_step)
		else $error("input taken while busy");
	a_clear_no_update: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !(cmd.acq_upd || cmd.rel_upd || cmd.out_load))
		else $error("lock update during clearing pass");
	a_check_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == S_CHECK) || $past(sts.cfg_wr))
		else $error("accepted request not checked");

endmodule
`default_nettype wire

[sv/qtl_dp.sv]
`default_nettype none
module qtl_dp
	import qtl_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cfg_t cfg,
	input  wire logic cfg_wr,
	input  wire req_t req_pl,
	input  wire cmd_t cmd,
	output sts_t      sts,
	output evt_t      evt_pl,
	output logic      evt_valid,
	input  wire logic evt_ready
);

	logic [7:0] node_mem [0:NODE_COUNT-1];
	logic [2:0] ring_mem [0:RING_DEPTH-1];

	logic [7:0]  node_q;
	logic [2:0]  ring_q;
	logic [8:0]  clr_q;
	req_t        item_q;
	logic [2:0]  lv_q;
	logic        push_q;
	logic [1:0]  code_q;
	logic        gn_q;
	logic [3:0]  cx_q;
	logic [3:0]  cy_q;
	logic        holder_valid_q;
	logic [3:0]  holder_x_q;
	logic [3:0]  holder_y_q;
	logic [2:0]  holder_task_q;
	evt_t        res_q;
	evt_t        out_q;
	logic        out_valid_q;

	logic [4:0]  eff_w;
	logic [4:0]  eff_h;
	logic [3:0]  eff_t;
	logic [4:0]  z;
	logic [2:0]  levels;
	logic [3:0]  nd_next;
	logic [3:0]  nd_srv;
	logic [3:0]  rel_next;
	logic [3:0]  rel_srv;
	logic [3:0]  diff;
	logic [3:0]  ax;
	logic [3:0]  ay;
	logic [8:0]  node_addr;
	logic        node_we;
	logic [8:0]  node_wa;
	logic [7:0]  node_wd;
	logic        ring_we;
	logic [2:0]  ring_wd;
	logic [2:0]  lvm1;

	always_comb begin
		eff_w = (cfg.grid_width > 5'(MAX_SIDE)) ? 5'(MAX_SIDE) : cfg.grid_width;
		eff_h = (cfg.grid_height > 5'(MAX_SIDE)) ? 5'(MAX_SIDE) : cfg.grid_height;
		eff_t = (cfg.tasks_per_cluster > 4'(MAX_TASKS)) ? 4'(MAX_TASKS) : cfg.tasks_per_cluster;
		z     = (eff_w > eff_h) ? eff_w : eff_h;
		priority if (z <= 5'd1) levels = 3'd1;
		else if (z <= 5'd2) levels = 3'd2;
		else if (z <= 5'd4) levels = 3'd3;
		else if (z <= 5'd8) levels = 3'd4;
		else levels = 3'(MAX_LEVELS);
	end

	assign nd_next   = node_q[7:4];
	assign nd_srv    = node_q[3:0];
	assign rel_next  = nd_next + {3'b0, push_q};
	assign rel_srv   = nd_srv + 4'd1;
	assign diff      = nd_next - nd_srv;
	assign ax        = gn_q ? cx_q : item_q.cluster_x;
	assign ay        = gn_q ? cy_q : item_q.cluster_y;
	assign node_addr = node_idx(ax, ay, lv_q);
	assign lvm1      = lv_q - 3'd1;

	always_comb begin
		node_we = cmd.clr_step || cmd.acq_upd || cmd.rel_upd;
		node_wa = node_addr;
		node_wd = {rel_next, rel_srv};
		if (cmd.clr_step) begin
			node_wa = clr_q;
			node_wd = '0;
		end else if (cmd.acq_upd) begin
			node_wd = {nd_next + 4'd1, nd_srv};
		end
		ring_we = cmd.acq_upd || (cmd.rel_upd && push_q);
		ring_wd = (cmd.acq_upd && lv_q == 3'd0) ? item_q.task_number : {1'b0, code_q};
	end

	always_ff @(posedge clk) begin
		if (node_we) node_mem[node_wa] <= node_wd;
		if (cmd.rd_node) node_q <= node_mem[node_addr];
	end

	always_ff @(posedge clk) begin
		if (ring_we) ring_mem[{node_addr, nd_next[2:0]}] <= ring_wd;
		if (cmd.gn_ring_rd) ring_q <= ring_mem[{node_addr, nd_srv[2:0]}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q          <= '0;
			lv_q           <= '0;
			push_q         <= 1'b0;
			gn_q           <= 1'b0;
			holder_valid_q <= 1'b0;
			holder_x_q     <= '0;
			holder_y_q     <= '0;
			holder_task_q  <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cmd.clr_restart) begin
				clr_q          <= '0;
				holder_valid_q <= 1'b0;
				holder_x_q     <= '0;
				holder_y_q     <= '0;
				holder_task_q  <= '0;
			end else if (cmd.clr_step) begin
				clr_q <= clr_q + 9'd1;
			end
			if (cmd.load) begin
				lv_q   <= '0;
				push_q <= 1'b0;
				gn_q   <= 1'b0;
			end
			if (cmd.acq_upd) lv_q <= lv_q + 3'd1;
			if (cmd.rel_upd) push_q <= rel_next != rel_srv;
			if (cmd.gn_init) begin
				lv_q <= levels - 3'd1;
				gn_q <= 1'b1;
			end else if (cmd.rel_upd) begin
				lv_q <= lv_q + 3'd1;
			end
			if (cmd.gn_descend) lv_q <= lvm1;
			if (cmd.holder_drop) holder_valid_q <= 1'b0;
			if (cmd.set_grant_req) begin
				holder_valid_q <= 1'b1;
				holder_x_q     <= item_q.cluster_x;
				holder_y_q     <= item_q.cluster_y;
				holder_task_q  <= item_q.task_number;
			end
			if (cmd.set_grant_root) begin
				holder_valid_q <= 1'b1;
				holder_x_q     <= cx_q;
				holder_y_q     <= cy_q;
				holder_task_q  <= ring_q;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (evt_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) item_q <= req_pl;
		if (cmd.acq_upd || cmd.rel_upd) begin
			code_q <= {item_q.cluster_y[lv_q[1:0]], item_q.cluster_x[lv_q[1:0]]};
		end
		if (cmd.gn_init) begin
			cx_q <= '0;
			cy_q <= '0;
		end
		if (cmd.gn_descend) begin
			cx_q[lvm1[1:0]] <= ring_q[0];
			cy_q[lvm1[1:0]] <= ring_q[1];
		end
		if (cmd.set_reject) begin
			res_q <= {EV_REJECT, item_q.cluster_x, item_q.cluster_y, item_q.task_number};
		end
		if (cmd.set_grant_req) begin
			res_q <= {EV_GRANT, item_q.cluster_x, item_q.cluster_y, item_q.task_number};
		end
		if (cmd.set_grant_root) res_q <= {EV_GRANT, cx_q, cy_q, ring_q};
		if (cmd.out_load) out_q <= res_q;
	end

	always_comb begin
		sts.cfg_wr      = cfg_wr;
		sts.clr_last    = clr_q == 9'(NODE_COUNT - 1);
		sts.bad         = ({1'b0, item_q.cluster_x} >= eff_w) ||
		                  ({1'b0, item_q.cluster_y} >= eff_h) ||
		                  ({1'b0, item_q.task_number} >= eff_t);
		sts.is_holder   = holder_valid_q && holder_x_q == item_q.cluster_x &&
		                  holder_y_q == item_q.cluster_y && holder_task_q == item_q.task_number;
		sts.rtype       = item_q.req_type;
		sts.full        = (lv_q == 3'd0) && diff[3];
		sts.held        = nd_next == nd_srv;
		sts.rel_pending = rel_next != rel_srv;
		sts.last_lv     = ({1'b0, lv_q} + 4'd1) >= {1'b0, levels};
		sts.lv_zero     = lv_q == 3'd0;
		sts.out_free    = !out_valid_q || evt_ready;
	end

	assign evt_pl    = out_q;
	assign evt_valid = out_valid_q;

	a_grant_sets_holder: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(holder_valid_q) |-> $past(cmd.set_grant_req || cmd.set_grant_root))
		else $error("holder set without a grant");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || evt_ready))
		else $error("pending result overwritten");
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.acq_upd || cmd.rel_upd || cmd.rd_node) |-> (lv_q < levels))
		else $error("tree level out of range");

endmodule
`default_nettype wire

[sv/quadtree_ticket_lock_manager.sv]
// Global lock built as a quad tree of ticket locks over a grid of clusters.
// Requests arrive on req (valid/ready); a transfer carries an acquire or a
// release from one task of one cluster. Results leave on evt (valid/ready):
// a grant names the new holder, a reject echoes the offending request.
// A request produces zero or one result.
// One request is handled at a time. The sequencer first runs the checks,
// then does a read-modify-write of the node memory for each tree level;
// a release that hands the lock on then walks down from the root, reading
// the node and then its entry in the waiter ring memory at each level.
// The result sits in an output register; a stalled receiver holds that
// register, and the next request is taken meanwhile, waiting only when it
// has a result of its own to give.
// After reset, and after every register write over the APB port, the node
// counters of all 341 nodes are cleared in a pass during which no request
// is taken; the holder is cleared at once.
`default_nettype none
module quadtree_ticket_lock_manager
	import qtl_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	qtl_req_if.sink          req,
	qtl_evt_if.source        evt,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	cfg_t cfg_q;
	logic cfg_wr;
	cmd_t cmd;
	sts_t sts;
	req_t req_pl;
	evt_t evt_pl;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready &&
	                (paddr[3:2] == REG_GRID_WIDTH || paddr[3:2] == REG_GRID_HEIGHT ||
	                 paddr[3:2] == REG_TASKS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grid_width        <= 5'(MAX_SIDE);
			cfg_q.grid_height       <= 5'(MAX_SIDE);
			cfg_q.tasks_per_cluster <= 4'(MAX_TASKS);
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_GRID_WIDTH:  cfg_q.grid_width        <= pwdata[4:0];
				REG_GRID_HEIGHT: cfg_q.grid_height       <= pwdata[4:0];
				REG_TASKS:       cfg_q.tasks_per_cluster <= pwdata[3:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_GRID_WIDTH:  prdata = {27'b0, cfg_q.grid_width};
			REG_GRID_HEIGHT: prdata = {27'b0, cfg_q.grid_height};
			REG_TASKS:       prdata = {28'b0, cfg_q.tasks_per_cluster};
			default:         prdata = '0;
		endcase
	end

	assign req_pl = {req.req_type, req.cluster_x, req.cluster_y, req.task_number};

	qtl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	qtl_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cfg_wr    (cfg_wr),
		.req_pl    (req_pl),
		.cmd       (cmd),
		.sts       (sts),
		.evt_pl    (evt_pl),
		.evt_valid (evt.valid),
		.evt_ready (evt.ready)
	);

	assign evt.event_kind = evt_pl.event_kind;
	assign evt.owner_x    = evt_pl.owner_x;
	assign evt.owner_y    = evt_pl.owner_y;
	assign evt.owner_task = evt_pl.owner_task;

endmodule
`default_nettype wire
